// ===== hw/rtl/assert_macros.svh =====
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/llph_pkg.sv =====
package llph_pkg;

    localparam int MAX_ROW_WIDTH_DEF = 1024;
    localparam int LINE_ROWS_DEF     = 512;
    localparam int SCAN_COLS_DEF     = 256;

    localparam logic [1:0] OP_PIXEL = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic KIND_PEAK = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_ROW_WIDTH = 2'd1;
    localparam logic [1:0] REG_DIGITIZE  = 2'd2;

    localparam logic [15:0] HEIGHT_FULL = 16'd65280;

    typedef enum logic [1:0] {
        CMD_PEAK,
        CMD_CLEAR,
        CMD_READ
    } cmd_kind_t;

    // one queued command from the front to the back
    typedef struct packed {
        cmd_kind_t   kind;
        logic [8:0]  row;
        logic [9:0]  pos;
        logic [15:0] power;
        logic        detected;
        logic        write_hm;
        logic [8:0]  spot;
        logic [7:0]  read_col;
    } cmd_t;

endpackage

// ===== hw/rtl/llph_front.sv =====
module llph_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          op,
    input  logic [15:0]         pixel,
    input  logic                last_in_row,
    input  logic                last_in_frame,
    input  logic signed [8:0]   slider_pos,
    input  logic [7:0]          read_col,
    input  logic [8:0]          read_row,
    input  logic [15:0]         line_threshold,
    input  logic                digitize_enable,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output llph_pkg::cmd_t      cmd
);

    logic [15:0] run_max_reg;
    logic [9:0]  run_pos_reg;
    logic [9:0]  col_count_reg;
    logic [8:0]  row_count_reg;
    logic [15:0] max_next;
    logic [9:0]  pos_next;
    logic        accept;
    logic        row_end;

    assign in_ready = cmd_ready;
    assign accept = in_valid && in_ready;
    assign row_end = last_in_row || last_in_frame;

    always_comb begin
        max_next = run_max_reg;
        pos_next = run_pos_reg;
        if (pixel > run_max_reg) begin
            max_next = pixel;
            pos_next = col_count_reg;
        end
    end

    always_comb begin
        cmd = '0;
        cmd_valid = 1'b0;
        cmd.row = row_count_reg;
        cmd.pos = pos_next;
        cmd.power = max_next;
        cmd.detected = (max_next >= line_threshold);
        cmd.spot = slider_pos;
        cmd.read_col = read_col;
        case (op)
            llph_pkg::OP_PIXEL: begin
                cmd.kind = llph_pkg::CMD_PEAK;
                cmd_valid = in_valid && row_end;
                cmd.write_hm = cmd.detected && digitize_enable && !slider_pos[8];
            end
            llph_pkg::OP_CLEAR: begin
                cmd.kind = llph_pkg::CMD_CLEAR;
                cmd_valid = in_valid;
            end
            llph_pkg::OP_READ: begin
                cmd.kind = llph_pkg::CMD_READ;
                cmd.row = read_row;
                cmd_valid = in_valid;
            end
            default: begin
                cmd.kind = llph_pkg::CMD_PEAK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_max_reg <= '0;
            run_pos_reg <= '0;
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else if (accept && op == llph_pkg::OP_PIXEL) begin
            if (row_end) begin
                run_max_reg <= '0;
                run_pos_reg <= '0;
                col_count_reg <= '0;
                row_count_reg <= last_in_frame ? 9'd0 : row_count_reg + 9'd1;
            end else begin
                run_max_reg <= max_next;
                run_pos_reg <= pos_next;
                col_count_reg <= col_count_reg + 10'd1;
            end
        end
    end

endmodule

// ===== hw/rtl/llph_queue.sv =====
module llph_queue #(
    parameter int DEPTH = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  llph_pkg::cmd_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output llph_pkg::cmd_t rd_data
);

    localparam int AW = $clog2(DEPTH);

    llph_pkg::cmd_t  mem_reg [DEPTH];
    logic [AW-1:0]   wp_reg;
    logic [AW-1:0]   rp_reg;
    logic [AW:0]     cnt_reg;
    logic            push;
    logic            pop;

    assign wr_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data = mem_reg[rp_reg];
    assign push = wr_valid && wr_ready;
    assign pop = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
            end
            if (pop) begin
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + AW'(1);
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule

// ===== hw/rtl/llph_back.sv =====
`include "assert_macros.svh"

module llph_back #(
    parameter int LINE_ROWS = llph_pkg::LINE_ROWS_DEF,
    parameter int SCAN_COLS = llph_pkg::SCAN_COLS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  llph_pkg::cmd_t cmd,
    input  logic [10:0]    row_width,
    output logic           m_valid,
    input  logic           m_ready,
    output logic           m_kind,
    output logic [8:0]     m_row_index,
    output logic [9:0]     m_peak_pos,
    output logic [15:0]    m_peak_power,
    output logic           m_detected,
    output logic [15:0]    m_height,
    output logic [15:0]    m_stored_power
);

    localparam int CW = $clog2(SCAN_COLS);
    localparam int DEPTH = SCAN_COLS * LINE_ROWS;
    localparam int AW = $clog2(DEPTH);
    localparam int PW = 26;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_DIV, S_RDREQ, S_RDWAIT, S_NBREQ, S_NBWAIT, S_NBWR,
        S_OUT
    } state_t;

    state_t         state_reg;
    llph_pkg::cmd_t cur_reg;
    logic [AW-1:0]  clr_reg;
    logic [4:0]     bit_reg;
    logic [PW-1:0]  num_reg;
    logic [PW-1:0]  quo_reg;
    logic [PW-1:0]  rem_reg;
    logic [15:0]    h_calc;
    logic [2:0]     nb_reg;
    logic [15:0]    p3_reg;
    logic [15:0]    p5_reg;
    logic [31:0]    hm_mem [DEPTH];
    logic [31:0]    rd_reg;
    logic [AW-1:0]  raddr;
    logic           ren;
    logic [AW-1:0]  waddr;
    logic [31:0]    wdata;
    logic           wen;
    logic signed [CW+2:0] nb_col;
    logic [PW-1:0]  rem_sh;
    logic           out_busy;
    logic [15:0]    nb_pow;
    logic           rd_in_map;
    logic           wr_in_map;

    always_ff @(posedge aclk) begin
        if (wen) begin
            hm_mem[waddr] <= wdata;
        end
        if (ren) begin
            rd_reg <= hm_mem[raddr];
        end
    end

    function automatic logic signed [CW+2:0] nb_off(input logic [2:0] i);
        case (i)
            3'd0: nb_off = -(CW+3)'(1);
            3'd1: nb_off = -(CW+3)'(2);
            3'd2: nb_off = (CW+3)'(1);
            default: nb_off = (CW+3)'(2);
        endcase
    endfunction

    // entry (col,row) sits at col*LINE_ROWS+row
    function automatic logic [AW-1:0] hm_addr(input logic [11:0] c, input logic [11:0] r);
        hm_addr = AW'(32'(c) * 32'(LINE_ROWS) + 32'(r));
    endfunction

    assign nb_col = $signed((CW+3)'(cur_reg.spot)) + nb_off(nb_reg);
    assign nb_pow = (nb_reg == 3'd0 || nb_reg == 3'd2) ? p3_reg : p5_reg;
    assign rem_sh = {rem_reg[PW-2:0], num_reg[bit_reg]};
    assign out_busy = m_valid && !m_ready;
    assign cmd_ready = (state_reg == S_IDLE) && !out_busy;
    assign rd_in_map = (32'(cur_reg.read_col) < 32'(SCAN_COLS))
        && (32'(cur_reg.row) < 32'(LINE_ROWS));
    assign wr_in_map = (32'(cur_reg.spot) < 32'(SCAN_COLS))
        && (32'(cur_reg.row) < 32'(LINE_ROWS));

    always_comb begin
        raddr = '0;
        ren = 1'b0;
        waddr = '0;
        wdata = '0;
        wen = 1'b0;
        case (state_reg)
            S_IDLE: begin
                ren = cmd_valid && cmd.kind == llph_pkg::CMD_READ;
                raddr = hm_addr(12'(cmd.read_col), 12'(cmd.row));
            end
            S_CLEAR: begin
                wen = 1'b1;
                waddr = clr_reg;
            end
            S_RDREQ: begin
                ren = 1'b1;
                raddr = hm_addr(12'(cur_reg.spot), 12'(cur_reg.row));
            end
            S_RDWAIT: begin
                wen = (cur_reg.power >= rd_reg[31:16]);
                waddr = hm_addr(12'(cur_reg.spot), 12'(cur_reg.row));
                wdata = {cur_reg.power, h_calc};
            end
            S_NBREQ: begin
                ren = 1'b1;
                raddr = hm_addr(12'(nb_col), 12'(cur_reg.row));
            end
            S_NBWR: begin
                wen = (rd_reg[31:16] == 16'd0);
                waddr = hm_addr(12'(nb_col), 12'(cur_reg.row));
                wdata = {nb_pow, h_calc};
            end
            default: begin
                wen = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            m_valid <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                m_valid <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (cmd_valid && cmd_ready) begin
                        cur_reg <= cmd;
                        case (cmd.kind)
                            llph_pkg::CMD_CLEAR: begin
                                clr_reg <= '0;
                                state_reg <= S_CLEAR;
                            end
                            llph_pkg::CMD_READ: begin
                                state_reg <= S_OUT;
                            end
                            default: begin
                                num_reg <= PW'(cmd.pos) * PW'(llph_pkg::HEIGHT_FULL);
                                quo_reg <= '0;
                                rem_reg <= '0;
                                bit_reg <= 5'(PW - 1);
                                p3_reg <= 16'((32'(cmd.power) * 32'd43691) >> 17);
                                p5_reg <= 16'((32'(cmd.power) * 32'd52429) >> 18);
                                state_reg <= S_DIV;
                            end
                        endcase
                    end
                end
                S_CLEAR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(DEPTH - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_DIV: begin
                    if (rem_sh >= PW'(row_width)) begin
                        rem_reg <= rem_sh - PW'(row_width);
                        quo_reg[bit_reg] <= 1'b1;
                    end else begin
                        rem_reg <= rem_sh;
                    end
                    bit_reg <= bit_reg - 5'd1;
                    if (bit_reg == 5'd0) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    m_valid <= 1'b1;
                    m_kind <= (cur_reg.kind == llph_pkg::CMD_READ)
                        ? llph_pkg::KIND_READ : llph_pkg::KIND_PEAK;
                    m_row_index <= cur_reg.row;
                    if (cur_reg.kind == llph_pkg::CMD_READ) begin
                        m_peak_pos <= '0;
                        m_peak_power <= '0;
                        m_detected <= 1'b0;
                        m_height <= rd_in_map ? rd_reg[15:0] : 16'd0;
                        m_stored_power <= rd_in_map ? rd_reg[31:16] : 16'd0;
                        state_reg <= S_IDLE;
                    end else begin
                        m_peak_pos <= cur_reg.pos;
                        m_peak_power <= cur_reg.power;
                        m_detected <= cur_reg.detected;
                        m_height <= h_calc;
                        m_stored_power <= '0;
                        nb_reg <= '0;
                        if (cur_reg.write_hm && wr_in_map) begin
                            state_reg <= S_RDREQ;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_RDREQ: begin
                    state_reg <= S_RDWAIT;
                end
                S_RDWAIT: begin
                    state_reg <= S_NBREQ;
                end
                S_NBREQ: begin
                    if (nb_col < 0 || nb_col >= (CW+3)'(SCAN_COLS)) begin
                        nb_reg <= nb_reg + 3'd1;
                        if (nb_reg == 3'd3) begin
                            state_reg <= S_IDLE;
                        end
                    end else begin
                        state_reg <= S_NBWAIT;
                    end
                end
                S_NBWAIT: begin
                    state_reg <= S_NBWR;
                end
                S_NBWR: begin
                    nb_reg <= nb_reg + 3'd1;
                    state_reg <= (nb_reg == 3'd3) ? S_IDLE : S_NBREQ;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // height from the quotient, saturated at zero
    always_comb begin
        if (row_width == 11'd0 || quo_reg >= PW'(llph_pkg::HEIGHT_FULL)) begin
            h_calc = '0;
        end else begin
            h_calc = llph_pkg::HEIGHT_FULL - quo_reg[15:0];
        end
    end

    `ASSERT_NEVER(a_no_accept_busy, cmd_ready && state_reg != S_IDLE, "accept while busy")
    `ASSERT_CLK(a_out_hold, m_valid && !m_ready |=> m_valid, "result dropped")
    `ASSERT_CLK(a_out_stable, m_valid && !m_ready |=> $stable(m_height), "result changed")

endmodule

// ===== hw/rtl/laser_line_peak_heightmap_unit.sv =====
// Row peak detector with heightmap writer. Pixels are accepted one per cycle while the
// four-entry command queue has room; each row end, clear and read becomes a queued command.
// The back end handles a row end by taking the command, running 26 steps of a bit-serial
// height divider and loading the result; a peak written into the heightmap then reads and
// writes the main entry, then each neighbour inside the map, and skips those outside it.
// A read fetches its entry and loads the result, and a clear sweeps the heightmap one
// entry per cycle over all SCAN_COLS*LINE_ROWS entries; the same sweep runs after reset
// before any row end, clear or read is served. The back end takes no new command while its result waits.
module laser_line_peak_heightmap_unit #(
    parameter int LINE_ROWS = llph_pkg::LINE_ROWS_DEF,
    parameter int SCAN_COLS = llph_pkg::SCAN_COLS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic [15:0]        s_pixel,
    input  logic               s_last_in_row,
    input  logic               s_last_in_frame,
    input  logic signed [8:0]  s_slider_pos,
    input  logic [7:0]         s_read_col,
    input  logic [8:0]         s_read_row,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_kind,
    output logic [8:0]         m_row_index,
    output logic [9:0]         m_peak_pos,
    output logic [15:0]        m_peak_power,
    output logic               m_detected,
    output logic [15:0]        m_height,
    output logic [15:0]        m_stored_power
);

    logic [15:0]    line_threshold_reg;
    logic [10:0]    row_width_reg;
    logic           digitize_enable_reg;
    logic           fq_valid;
    logic           fq_ready;
    llph_pkg::cmd_t fq_cmd;
    logic           qb_valid;
    logic           qb_ready;
    llph_pkg::cmd_t qb_cmd;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_threshold_reg <= '0;
            row_width_reg <= 11'd640;
            digitize_enable_reg <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                llph_pkg::REG_THRESHOLD: line_threshold_reg <= pwdata[15:0];
                llph_pkg::REG_ROW_WIDTH: row_width_reg <= pwdata[10:0];
                llph_pkg::REG_DIGITIZE:  digitize_enable_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            llph_pkg::REG_THRESHOLD: prdata = {16'd0, line_threshold_reg};
            llph_pkg::REG_ROW_WIDTH: prdata = {21'd0, row_width_reg};
            llph_pkg::REG_DIGITIZE:  prdata = {31'd0, digitize_enable_reg};
            default:                 prdata = '0;
        endcase
    end

    llph_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready),
        .op(s_op), .pixel(s_pixel), .last_in_row(s_last_in_row),
        .last_in_frame(s_last_in_frame), .slider_pos(s_slider_pos),
        .read_col(s_read_col), .read_row(s_read_row),
        .line_threshold(line_threshold_reg), .digitize_enable(digitize_enable_reg),
        .cmd_valid(fq_valid), .cmd_ready(fq_ready), .cmd(fq_cmd)
    );

    llph_queue #(.DEPTH(4)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_cmd),
        .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_cmd)
    );

    llph_back #(.LINE_ROWS(LINE_ROWS), .SCAN_COLS(SCAN_COLS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(qb_valid), .cmd_ready(qb_ready), .cmd(qb_cmd),
        .row_width(row_width_reg),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
        .m_row_index(m_row_index), .m_peak_pos(m_peak_pos),
        .m_peak_power(m_peak_power), .m_detected(m_detected),
        .m_height(m_height), .m_stored_power(m_stored_power)
    );

endmodule
